// ===== design/bos_pkg.sv =====
// shared types and constants for the box overlap suppression block
package bos_pkg;

  localparam int CoordW     = 12;
  localparam int ThrW       = 24;
  localparam int AreaW      = 2 * CoordW;
  localparam int CmpW       = (AreaW > ThrW) ? AreaW : ThrW;
  localparam int MaxBoxes   = 64;
  localparam int QueueDepth = 2;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(6);

  typedef struct packed {
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_top;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [CoordW-1:0] center_col;
    logic [CoordW-1:0] center_row;
    logic              final_box;
  } box_in_t;

  typedef struct packed {
    logic [CoordW-1:0] kept_left;
    logic [CoordW-1:0] kept_top;
    logic [CoordW-1:0] kept_width;
    logic [CoordW-1:0] kept_height;
    logic [CoordW-1:0] kept_center_col;
    logic [CoordW-1:0] kept_center_row;
    logic              list_empty;
    logic              overflowed;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
  } box_t;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } center_t;

  // queued item with its classification
  typedef struct packed {
    box_in_t box;
    logic    alive;
  } q_item_t;

endpackage

// ===== design/bos_ram.sv =====
// generic single write port ram with registered read
module bos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bos_front.sv =====
// front end: accepts boxes, classifies them and queues them for the back end
module bos_front import bos_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  box_in_t box_i,
  output logic    busy_o,
  output q_item_t q_item_o,
  output logic    q_valid_o,
  input  logic    q_pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  q_item_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, push, pop;
  q_item_t         item;

  assign full      = (cnt_q == CntFull);
  assign push      = start_i && !full;
  assign pop       = q_pop_i && (cnt_q != '0);
  assign busy_o    = full;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  // a zero width box takes a slot but never survives
  always_comb begin
    item.box   = box_i;
    item.alive = (box_i.box_width != '0);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== design/bos_back.sv =====
// back end: box store, greedy suppression sweeps and survivor output
module bos_back import bos_pkg::*; #(
  parameter int MAX_BOXES = MaxBoxes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ThrW-1:0] threshold_i,
  input  q_item_t         q_item_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam int IdxW = $clog2(MAX_BOXES);
  localparam int CntW = $clog2(MAX_BOXES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BOXES);

  typedef enum logic [4:0] {
    StLoad  = 5'b00001,
    StIsel  = 5'b00010,
    StIlat  = 5'b00100,
    StSweep = 5'b01000,
    StEmit  = 5'b10000
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_BOXES-1:0] alive_q, alive_d;
  logic [CntW-1:0]      i_q, i_d;
  logic [CntW-1:0]      j_q, j_d;
  logic                 r1v_q, r1v_d;
  logic [IdxW-1:0]      jr_q, jr_d;
  logic                 s2v_q, s2v_d;
  logic [IdxW-1:0]      j2_q, j2_d;
  logic [CoordW-1:0]    ovx_q, ovx_d, ovy_q, ovy_d;
  logic                 pos_q, pos_d;
  box_t                 bi_q, bi_d;
  box_t                 pend_box_q, pend_box_d;
  center_t              pend_ctr_q, pend_ctr_d;
  logic                 pend_v_q, pend_v_d;
  result_t              res_q, res_d;
  logic                 res_v_q, res_v_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  box_t            box_wdata, box_rdata;
  center_t         ctr_wdata, ctr_rdata;

  // overlap per axis of the held box against the box just read
  logic [CoordW:0]    ra, rb, ba, bb, x2, y2;
  logic [CoordW-1:0]  x1, y1;
  logic [AreaW-1:0]   area;
  logic               kill;

  bos_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_box_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (box_wdata),
    .raddr_i (raddr),
    .rdata_o (box_rdata)
  );

  bos_ram #(.WIDTH($bits(center_t)), .DEPTH(MAX_BOXES)) u_center_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ctr_wdata),
    .raddr_i (raddr),
    .rdata_o (ctr_rdata)
  );

  assign waddr     = cnt_q[IdxW-1:0];
  assign box_wdata = '{left:   q_item_i.box.box_left,
                       top:    q_item_i.box.box_top,
                       width:  q_item_i.box.box_width,
                       height: q_item_i.box.box_height};
  assign ctr_wdata = '{col: q_item_i.box.center_col,
                       row: q_item_i.box.center_row};

  always_comb begin
    ra = {1'b0, bi_q.left} + {1'b0, bi_q.width};
    rb = {1'b0, box_rdata.left} + {1'b0, box_rdata.width};
    ba = {1'b0, bi_q.top} + {1'b0, bi_q.height};
    bb = {1'b0, box_rdata.top} + {1'b0, box_rdata.height};
    x1 = (bi_q.left > box_rdata.left) ? bi_q.left : box_rdata.left;
    y1 = (bi_q.top > box_rdata.top) ? bi_q.top : box_rdata.top;
    x2 = (ra < rb) ? ra : rb;
    y2 = (ba < bb) ? ba : bb;
    pos_d = (x2 >= {1'b0, x1}) && (y2 >= {1'b0, y1});
    ovx_d = CoordW'(x2 - {1'b0, x1});
    ovy_d = CoordW'(y2 - {1'b0, y1});
    j2_d  = jr_q;
    s2v_d = r1v_q && (state_q == StSweep);
  end

  assign area = AreaW'(ovx_q) * AreaW'(ovy_q);
  assign kill = s2v_q && pos_q && (CmpW'(area) > CmpW'(threshold_i))
                && (j2_q != i_q[IdxW-1:0]);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    alive_d    = alive_q;
    i_d        = i_q;
    j_d        = j_q;
    r1v_d      = 1'b0;
    jr_d       = jr_q;
    bi_d       = bi_q;
    pend_box_d = pend_box_q;
    pend_ctr_d = pend_ctr_q;
    pend_v_d   = pend_v_q;
    res_d      = res_q;
    res_v_d    = 1'b0;
    we         = 1'b0;
    raddr      = '0;
    q_pop_o    = 1'b0;

    case (state_q)
      StLoad: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (cnt_q != CntMax) begin
            we                          = 1'b1;
            alive_d[cnt_q[IdxW-1:0]]    = q_item_i.alive;
            cnt_d                       = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (q_item_i.box.final_box) begin
            i_d     = '0;
            state_d = StIsel;
          end
        end
      end
      StIsel: begin
        raddr = i_q[IdxW-1:0];
        if (i_q == cnt_q) begin
          i_d     = '0;
          state_d = StEmit;
        end else if (alive_q[i_q[IdxW-1:0]]) begin
          state_d = StIlat;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      StIlat: begin
        bi_d    = box_rdata;
        j_d     = '0;
        state_d = StSweep;
      end
      StSweep: begin
        if (j_q != cnt_q) begin
          raddr = j_q[IdxW-1:0];
          r1v_d = 1'b1;
          jr_d  = j_q[IdxW-1:0];
          j_d   = j_q + 1'b1;
        end else if (!r1v_q && !s2v_q) begin
          i_d     = i_q + 1'b1;
          state_d = StIsel;
        end
      end
      StEmit: begin
        if (i_q != cnt_q) begin
          raddr = i_q[IdxW-1:0];
          r1v_d = alive_q[i_q[IdxW-1:0]];
          i_d   = i_q + 1'b1;
        end
        // one survivor is held back so the last one can be marked
        if (r1v_q) begin
          pend_box_d = box_rdata;
          pend_ctr_d = ctr_rdata;
          pend_v_d   = 1'b1;
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d   = '{kept_left: pend_box_q.left, kept_top: pend_box_q.top,
                        kept_width: pend_box_q.width, kept_height: pend_box_q.height,
                        kept_center_col: pend_ctr_q.col, kept_center_row: pend_ctr_q.row,
                        list_empty: 1'b0, overflowed: ovf_q, last_result: 1'b0};
          end
        end else if (i_q == cnt_q) begin
          res_v_d = 1'b1;
          if (pend_v_q) begin
            res_d = '{kept_left: pend_box_q.left, kept_top: pend_box_q.top,
                      kept_width: pend_box_q.width, kept_height: pend_box_q.height,
                      kept_center_col: pend_ctr_q.col, kept_center_row: pend_ctr_q.row,
                      list_empty: 1'b0, overflowed: ovf_q, last_result: 1'b1};
          end else begin
            res_d             = '0;
            res_d.list_empty  = 1'b1;
            res_d.overflowed  = ovf_q;
            res_d.last_result = 1'b1;
          end
          pend_v_d = 1'b0;
          cnt_d    = '0;
          ovf_d    = 1'b0;
          state_d  = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase

    if (kill) begin
      alive_d[j2_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      alive_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      r1v_q    <= 1'b0;
      s2v_q    <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      alive_q  <= alive_d;
      i_q      <= i_d;
      j_q      <= j_d;
      r1v_q    <= r1v_d;
      s2v_q    <= s2v_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jr_q       <= jr_d;
    j2_q       <= j2_d;
    ovx_q      <= ovx_d;
    ovy_q      <= ovy_d;
    pos_q      <= pos_d;
    bi_q       <= bi_d;
    pend_box_q <= pend_box_d;
    pend_ctr_q <= pend_ctr_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

// ===== design/box_overlap_suppression.sv =====
// top level of the greedy box overlap suppression block
//
//  channel   ports                              transaction at rising edge
//  ------------------------------------------------------------------------
//  box in    start_i, busy_o, box_i             start_i high and busy_o low
//  result    result_strobe_o, result_o          result_strobe_o high
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i  cfg_valid_i and cfg_ready_o
//
// boxes are queued and written to the store at one per cycle while the back
// end is loading; the final box starts the sweeps. each surviving box visited
// is compared against every stored box through the single store read port, and
// output reads each stored box once more. busy_o is high while the queue is
// full. after reset the block is ready at once. results cannot be stalled.
module box_overlap_suppression import bos_pkg::*; #(
  parameter int MAX_BOXES = MaxBoxes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  box_in_t         box_i,
  output logic            result_strobe_o,
  output result_t         result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ThrW-1:0] cfg_data_i
);

  logic [ThrW-1:0] thr_q;
  q_item_t         q_item;
  logic            q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  bos_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .box_i     (box_i),
    .busy_o    (busy_o),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  bos_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .q_item_i    (q_item),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .res_valid_o (result_strobe_o),
    .res_o       (result_o)
  );

  // an empty list gives exactly one result, marked last, with its box fields zero
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.list_empty |->
      result_o.last_result && (result_o.kept_width == '0))
    else $error("empty result not last or not cleared");

  // zero width boxes never come out
  a_kept_has_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !result_o.list_empty |-> (result_o.kept_width != '0))
    else $error("zero width box emitted");

  // a new list needs loading and sweeps before its first result
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.last_result |=> !result_strobe_o)
    else $error("result right after last result");

endmodule
